// ----- design/book_level_price_band_aggregator_unit_defines.svh -----
// Assertion macros shared by the aggregator RTL.
// Define ASSERT_OFF to compile the checks out.
`ifndef BOOK_LEVEL_PRICE_BAND_AGGREGATOR_UNIT_DEFINES_SVH
`define BOOK_LEVEL_PRICE_BAND_AGGREGATOR_UNIT_DEFINES_SVH

`ifndef ASSERT_OFF
// Clocked check with a fixed message
`define BLPBA_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("blpba: assertion failed");
// Clocked check with a caller message
`define BLPBA_ASSERT_MSG(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);
`else
`define BLPBA_ASSERT(lbl, clk, rst_n, prop)
`define BLPBA_ASSERT_MSG(lbl, clk, rst_n, prop, msg)
`endif

`endif

// ----- design/blpba_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package blpba_pkg;

    // Field widths
    localparam int PRICE_W     = 32;
    localparam int SIZE_W      = 24;
    localparam int GIDX_W      = 4;
    localparam int TOTAL_W     = 40;
    localparam int PZ_W        = PRICE_W + SIZE_W;
    localparam int PSS_W       = 64;
    localparam int LIMIT_W     = PRICE_W + 1;
    localparam int BAND_PROD_W = PRICE_W + 17;
    localparam int IN_TDATA_W  = 56;
    localparam int OUT_TDATA_W = 80;

    // Configuration
    localparam int RATIO_W      = 17;
    localparam int MAXG_W       = 5;
    localparam int CFG_IDX_W    = 1;
    localparam int CFG_DATA_W   = 17;
    localparam int MAX_GROUPS_DEF = 16;
    localparam logic [MAXG_W-1:0]  MAX_GROUPS_RST = 5'd16;
    localparam logic [RATIO_W-1:0] Q16_ONE        = 17'd65536;
    localparam logic [15:0]        Q16_ONE_M1     = 16'hFFFF;

    localparam logic [CFG_IDX_W-1:0] CFG_BAND_RATIO = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_GROUPS = 1'd1;

    // Divider geometry
    localparam int DIV_QUO_W = 32;
    localparam int DIV_CNT_W = $clog2(DIV_QUO_W);

    typedef struct packed {
        logic                start;
        logic [PSS_W-1:0]    dividend;
        logic [TOTAL_W-1:0]  divisor;
    } div_req_t;

    typedef struct packed {
        logic                 busy;
        logic                 done;
        logic [DIV_QUO_W-1:0] quotient;
    } div_rsp_t;

    // Sequencer states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL_PZ,
        ST_DECIDE,
        ST_EMIT0,
        ST_ABSORB,
        ST_CHECK_OPEN,
        ST_MUL_BAND,
        ST_OPEN,
        ST_CHECK_LAST,
        ST_CLOSE,
        ST_DIV,
        ST_EMIT
    } state_t;

    // Where the sequencer continues after a group close is sent
    typedef enum logic [1:0] {
        RES_SIDE,
        RES_OPEN,
        RES_LAST
    } resume_t;

endpackage

`default_nettype wire

// ----- design/blpba_div.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Restoring radix-2 divider, one quotient bit per cycle.
// Quotient is capped at all ones when it does not fit in DIV_QUO_W bits.
module blpba_div (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire blpba_pkg::div_req_t  req,
    output blpba_pkg::div_rsp_t       rsp
);

    localparam int QW = blpba_pkg::DIV_QUO_W;
    localparam int DW = blpba_pkg::TOTAL_W;
    localparam int CW = blpba_pkg::DIV_CNT_W;

    logic          busy_reg;
    logic          done_reg;
    logic [CW-1:0] cnt_reg;
    logic [DW-1:0] rem_reg;
    logic [DW-1:0] dsr_reg;
    logic [QW-1:0] quo_reg;

    logic [DW:0]   trial;
    logic [DW:0]   diff;
    logic          ge;
    logic          ovf;

    // Overflow when the high half already reaches the divisor
    assign ovf   = DW'(req.dividend[blpba_pkg::PSS_W-1:QW]) >= req.divisor;
    assign trial = {rem_reg, quo_reg[QW-1]};
    assign ge    = trial >= {1'b0, dsr_reg};
    assign diff  = trial - {1'b0, dsr_reg};

    // Control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (req.start) begin
                if (ovf) begin
                    done_reg <= 1'b1;
                end else begin
                    busy_reg <= 1'b1;
                    cnt_reg  <= CW'(QW - 1);
                end
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == '0) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Remainder and quotient shift
    always_ff @(posedge aclk) begin
        if (req.start) begin
            dsr_reg <= req.divisor;
            if (ovf) begin
                quo_reg <= '1;
            end else begin
                rem_reg <= DW'(req.dividend[blpba_pkg::PSS_W-1:QW]);
                quo_reg <= req.dividend[QW-1:0];
            end
        end else if (busy_reg) begin
            rem_reg <= ge ? diff[DW-1:0] : trial[DW-1:0];
            quo_reg <= {quo_reg[QW-2:0], ge};
        end
    end

    assign rsp.busy     = busy_reg;
    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

endmodule

`default_nettype wire

// ----- design/book_level_price_band_aggregator_unit.sv -----
// Order-book depth aggregator. Levels of one book side arrive on the s_ stream
// (bids best first, asks best first); level zero goes out at once as group 0,
// later levels are merged into price bands and each closed band goes out on the
// m_ stream with its volume-weighted average price and total size.
// cfg_we/cfg_idx/cfg_wdata write band_ratio_q16 (index 0) and max_groups
// (index 1); write them only while the block is idle.
// A group close with a nonzero total size runs the radix-2 divider, 32 steps;
// a level can close two groups (band break plus end of side), one after the other.
// Ready drops for the whole time an item is being worked on.
// Results sit in an output register; the next level is taken while the last
// result still waits. A stalled receiver holds the sequencer only when a
// further result must be sent.
// Reset (aresetn low, synchronous) clears the group state, empties the output
// register and sets band_ratio_q16 to 0 and max_groups to 16.
`timescale 1ns / 1ps
`default_nettype none
`include "book_level_price_band_aggregator_unit_defines.svh"

module book_level_price_band_aggregator_unit #(
    parameter int MAX_GROUPS = blpba_pkg::MAX_GROUPS_DEF
) (
    input  wire logic                                  aclk,
    input  wire logic                                  aresetn,
    // Configuration write port
    input  wire logic                                  cfg_we,
    input  wire logic [blpba_pkg::CFG_IDX_W-1:0]       cfg_idx,
    input  wire logic [blpba_pkg::CFG_DATA_W-1:0]      cfg_wdata,
    // Level input
    input  wire logic                                  s_tvalid,
    output logic                                       s_tready,
    input  wire logic [blpba_pkg::IN_TDATA_W-1:0]      s_tdata,  // price[31:0], size[55:32]
    input  wire logic                                  s_tlast,  // last_level
    input  wire logic                                  s_tuser,  // side
    // Group output
    output logic                                       m_tvalid,
    input  wire logic                                  m_tready,
    output logic [blpba_pkg::OUT_TDATA_W-1:0]          m_tdata,  // group_index[3:0],
                                                                 // average_price[35:4],
                                                                 // total_size[75:36], zero
    output logic                                       m_tlast,  // last_group
    output logic                                       m_tuser   // side_res
);

    localparam int IDXW = $clog2(MAX_GROUPS + 1);
    localparam int PW   = blpba_pkg::PRICE_W;
    localparam int ZW   = blpba_pkg::SIZE_W;
    localparam int TW   = blpba_pkg::TOTAL_W;
    localparam int SW   = blpba_pkg::PSS_W;
    localparam int LW   = blpba_pkg::LIMIT_W;
    localparam int BW   = blpba_pkg::BAND_PROD_W;
    localparam int PZW  = blpba_pkg::PZ_W;

    // Sequencer
    blpba_pkg::state_t  state_reg, state_next;
    blpba_pkg::resume_t resume_reg, resume_next;

    // Configuration
    logic [blpba_pkg::RATIO_W-1:0] band_ratio_reg;
    logic [blpba_pkg::MAXG_W-1:0]  max_groups_reg;

    // Captured level
    logic          in_side_reg;
    logic [PW-1:0] in_price_reg;
    logic [ZW-1:0] in_size_reg;
    logic          in_last_reg;

    // Group state
    logic            group_open_reg;
    logic [IDXW-1:0] nidx_reg;
    logic            side_done_reg;
    logic            gside_reg;
    logic [PW-1:0]   opening_reg;
    logic [LW-1:0]   band_limit_reg;
    logic [TW-1:0]   size_sum_reg;
    logic [SW-1:0]   pss_reg;
    logic [PW-1:0]   avg_reg;
    logic [PZW-1:0]  pz_reg;
    logic [BW-1:0]   band_prod_reg;

    // Output register
    logic                                m_tvalid_reg;
    logic [blpba_pkg::OUT_TDATA_W-1:0]   m_tdata_reg;
    logic                                m_tlast_reg;
    logic                                m_tuser_reg;

    // Divider
    blpba_pkg::div_req_t div_req;
    blpba_pkg::div_rsp_t div_rsp;

    // Derived values
    logic [IDXW-1:0]              eff_g;
    logic [IDXW:0]                nidx_inc;
    logic                         last_by_count;
    logic                         g_is_one;
    logic                         nidx_at_limit;
    logic                         side_change;
    logic                         in_band;
    logic                         out_free;
    logic [blpba_pkg::RATIO_W-1:0] ratio_sat;
    logic [ZW-1:0]                mul_b;
    logic [PZW-1:0]               mul_p;
    logic [BW:0]                  bid_lim_sum;
    logic [LW-1:0]                new_limit;
    logic [TW:0]                  size_add;
    logic [SW:0]                  pss_add;

    // Sequencer outputs
    logic ld_in;
    logic ld_pz;
    logic ld_band;
    logic do_absorb;
    logic do_open;
    logic do_limit;
    logic do_emit0;
    logic do_emit_close;
    logic do_end_side;
    logic ld_avg_open;
    logic ld_avg_div;

    // Group count clamped to 1..MAX_GROUPS
    always_comb begin
        if (max_groups_reg == '0) begin
            eff_g = IDXW'(1);
        end else if (int'(max_groups_reg) > MAX_GROUPS) begin
            eff_g = IDXW'(MAX_GROUPS);
        end else begin
            eff_g = IDXW'(max_groups_reg);
        end
    end

    assign nidx_inc      = (IDXW+1)'(nidx_reg) + 1'b1;
    assign last_by_count = nidx_inc >= (IDXW+1)'(eff_g);
    assign g_is_one      = eff_g == IDXW'(1);
    assign nidx_at_limit = nidx_reg >= eff_g;
    assign side_change   = (nidx_reg != '0) && (in_side_reg != gside_reg);
    assign in_band       = gside_reg ? ({1'b0, in_price_reg} <= band_limit_reg)
                                     : ({1'b0, in_price_reg} >= band_limit_reg);
    assign out_free      = !m_tvalid_reg || m_tready;

    // Shared multiplier: price times size, or price times band factor
    assign ratio_sat = (band_ratio_reg > blpba_pkg::Q16_ONE) ? blpba_pkg::Q16_ONE
                                                             : band_ratio_reg;
    always_comb begin
        if (state_reg == blpba_pkg::ST_MUL_BAND) begin
            if (gside_reg) begin
                mul_b = ZW'({1'b0, blpba_pkg::Q16_ONE} + {1'b0, ratio_sat});
            end else begin
                mul_b = ZW'({1'b0, blpba_pkg::Q16_ONE} - {1'b0, ratio_sat});
            end
        end else begin
            mul_b = in_size_reg;
        end
    end
    assign mul_p = PZW'(in_price_reg) * PZW'(mul_b);

    // Band bound: ceiling for bids, floor for asks
    assign bid_lim_sum = (BW+1)'(band_prod_reg) + (BW+1)'(blpba_pkg::Q16_ONE_M1);
    assign new_limit   = gside_reg ? band_prod_reg[BW-1:16] : LW'(bid_lim_sum[BW:16]);

    // Saturating sums
    assign size_add = {1'b0, size_sum_reg} + (TW+1)'(in_size_reg);
    assign pss_add  = {1'b0, pss_reg} + (SW+1)'(pz_reg);

    // Next state
    always_comb begin
        state_next  = state_reg;
        resume_next = resume_reg;
        unique case (state_reg)
            blpba_pkg::ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = blpba_pkg::ST_MUL_PZ;
                end
            end
            blpba_pkg::ST_MUL_PZ: begin
                state_next = blpba_pkg::ST_DECIDE;
            end
            blpba_pkg::ST_DECIDE: begin
                if (side_change) begin
                    resume_next = blpba_pkg::RES_SIDE;
                    if (group_open_reg) begin
                        state_next = blpba_pkg::ST_CLOSE;
                    end
                end else if (nidx_reg == '0) begin
                    state_next = blpba_pkg::ST_EMIT0;
                end else if (!side_done_reg) begin
                    resume_next = blpba_pkg::RES_OPEN;
                    if (group_open_reg && in_band) begin
                        state_next = blpba_pkg::ST_ABSORB;
                    end else if (group_open_reg) begin
                        state_next = blpba_pkg::ST_CLOSE;
                    end else begin
                        state_next = blpba_pkg::ST_CHECK_OPEN;
                    end
                end else begin
                    state_next = blpba_pkg::ST_CHECK_LAST;
                end
            end
            blpba_pkg::ST_EMIT0: begin
                if (out_free) begin
                    state_next = blpba_pkg::ST_IDLE;
                end
            end
            blpba_pkg::ST_ABSORB: begin
                state_next = blpba_pkg::ST_CHECK_LAST;
            end
            blpba_pkg::ST_CHECK_OPEN: begin
                if (!side_done_reg && !nidx_at_limit) begin
                    state_next = blpba_pkg::ST_MUL_BAND;
                end else begin
                    state_next = blpba_pkg::ST_CHECK_LAST;
                end
            end
            blpba_pkg::ST_MUL_BAND: begin
                state_next = blpba_pkg::ST_OPEN;
            end
            blpba_pkg::ST_OPEN: begin
                state_next = blpba_pkg::ST_CHECK_LAST;
            end
            blpba_pkg::ST_CHECK_LAST: begin
                resume_next = blpba_pkg::RES_LAST;
                if (in_last_reg && group_open_reg) begin
                    state_next = blpba_pkg::ST_CLOSE;
                end else begin
                    state_next = blpba_pkg::ST_IDLE;
                end
            end
            blpba_pkg::ST_CLOSE: begin
                if (size_sum_reg == '0) begin
                    state_next = blpba_pkg::ST_EMIT;
                end else begin
                    state_next = blpba_pkg::ST_DIV;
                end
            end
            blpba_pkg::ST_DIV: begin
                if (div_rsp.done) begin
                    state_next = blpba_pkg::ST_EMIT;
                end
            end
            blpba_pkg::ST_EMIT: begin
                if (out_free) begin
                    unique case (resume_reg)
                        blpba_pkg::RES_SIDE: state_next = blpba_pkg::ST_DECIDE;
                        blpba_pkg::RES_OPEN: state_next = blpba_pkg::ST_CHECK_OPEN;
                        default:             state_next = blpba_pkg::ST_IDLE;
                    endcase
                end
            end
            default: begin
                state_next = blpba_pkg::ST_IDLE;
            end
        endcase
    end

    // Sequencer outputs
    always_comb begin
        s_tready      = 1'b0;
        ld_in         = 1'b0;
        ld_pz         = 1'b0;
        ld_band       = 1'b0;
        do_absorb     = 1'b0;
        do_open       = 1'b0;
        do_limit      = 1'b0;
        do_emit0      = 1'b0;
        do_emit_close = 1'b0;
        do_end_side   = 1'b0;
        ld_avg_open   = 1'b0;
        ld_avg_div    = 1'b0;
        unique case (state_reg)
            blpba_pkg::ST_IDLE: begin
                s_tready = 1'b1;
                ld_in    = s_tvalid;
            end
            blpba_pkg::ST_MUL_PZ: begin
                ld_pz = 1'b1;
            end
            blpba_pkg::ST_DECIDE: begin
                do_end_side = side_change && !group_open_reg;
            end
            blpba_pkg::ST_EMIT0: begin
                do_emit0 = out_free;
            end
            blpba_pkg::ST_ABSORB: begin
                do_absorb = 1'b1;
            end
            blpba_pkg::ST_CHECK_OPEN: begin
                do_limit = !side_done_reg && nidx_at_limit;
            end
            blpba_pkg::ST_MUL_BAND: begin
                ld_band = 1'b1;
            end
            blpba_pkg::ST_OPEN: begin
                do_open = 1'b1;
            end
            blpba_pkg::ST_CHECK_LAST: begin
                do_end_side = in_last_reg && !group_open_reg;
            end
            blpba_pkg::ST_CLOSE: begin
                ld_avg_open = size_sum_reg == '0;
            end
            blpba_pkg::ST_DIV: begin
                ld_avg_div = div_rsp.done;
            end
            blpba_pkg::ST_EMIT: begin
                do_emit_close = out_free;
                do_end_side   = out_free && (resume_reg != blpba_pkg::RES_OPEN);
            end
            default: begin
                s_tready = 1'b0;
            end
        endcase
    end

    // Divider request
    assign div_req.start    = (state_reg == blpba_pkg::ST_CLOSE) && (size_sum_reg != '0);
    assign div_req.dividend = pss_reg;
    assign div_req.divisor  = size_sum_reg;

    blpba_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= blpba_pkg::ST_IDLE;
            resume_reg     <= blpba_pkg::RES_SIDE;
            band_ratio_reg <= '0;
            max_groups_reg <= blpba_pkg::MAX_GROUPS_RST;
            group_open_reg <= 1'b0;
            nidx_reg       <= '0;
            side_done_reg  <= 1'b0;
            gside_reg      <= 1'b0;
            m_tvalid_reg   <= 1'b0;
        end else begin
            state_reg  <= state_next;
            resume_reg <= resume_next;

            // Configuration decode
            if (cfg_we) begin
                unique case (cfg_idx)
                    blpba_pkg::CFG_BAND_RATIO: band_ratio_reg <= cfg_wdata;
                    blpba_pkg::CFG_MAX_GROUPS:
                        max_groups_reg <= cfg_wdata[blpba_pkg::MAXG_W-1:0];
                    default: band_ratio_reg <= band_ratio_reg;
                endcase
            end

            // Level zero opens the side
            if (do_emit0) begin
                gside_reg     <= in_side_reg;
                nidx_reg      <= IDXW'(1);
                side_done_reg <= g_is_one;
            end
            if (do_limit) begin
                side_done_reg <= 1'b1;
            end
            if (do_open) begin
                group_open_reg <= 1'b1;
            end
            if (do_emit_close) begin
                nidx_reg       <= nidx_inc[IDXW-1:0];
                group_open_reg <= 1'b0;
                if (last_by_count) begin
                    side_done_reg <= 1'b1;
                end
            end
            // End of side overrides the updates above
            if (do_end_side || (do_emit0 && in_last_reg)) begin
                group_open_reg <= 1'b0;
                nidx_reg       <= '0;
                side_done_reg  <= 1'b0;
            end

            // Output valid
            if (do_emit0 || do_emit_close) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // Datapath registers
    always_ff @(posedge aclk) begin
        if (ld_in) begin
            in_side_reg  <= s_tuser;
            in_price_reg <= s_tdata[PW-1:0];
            in_size_reg  <= s_tdata[PW+ZW-1:PW];
            in_last_reg  <= s_tlast;
        end
        if (ld_pz) begin
            pz_reg <= mul_p;
        end
        if (ld_band) begin
            band_prod_reg <= mul_p[BW-1:0];
        end
        if (do_open) begin
            opening_reg    <= in_price_reg;
            band_limit_reg <= new_limit;
            size_sum_reg   <= TW'(in_size_reg);
            pss_reg        <= SW'(pz_reg);
        end
        if (do_absorb) begin
            size_sum_reg <= size_add[TW] ? '1 : size_add[TW-1:0];
            pss_reg      <= pss_add[SW] ? '1 : pss_add[SW-1:0];
        end
        if (ld_avg_open) begin
            avg_reg <= opening_reg;
        end
        if (ld_avg_div) begin
            avg_reg <= div_rsp.quotient;
        end
        // Result transfer staging
        if (do_emit0) begin
            m_tuser_reg <= in_side_reg;
            m_tlast_reg <= in_last_reg || g_is_one;
            m_tdata_reg <= {4'b0, TW'(in_size_reg), in_price_reg,
                            blpba_pkg::GIDX_W'(0)};
        end
        if (do_emit_close) begin
            m_tuser_reg <= gside_reg;
            m_tlast_reg <= (resume_reg != blpba_pkg::RES_OPEN) || last_by_count;
            m_tdata_reg <= {4'b0, size_sum_reg, avg_reg,
                            blpba_pkg::GIDX_W'(nidx_reg)};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;
    assign m_tuser  = m_tuser_reg;

    // Checks
    `BLPBA_ASSERT(a_open_after_top, aclk, aresetn, group_open_reg |-> (nidx_reg != '0))
    `BLPBA_ASSERT(a_done_closed, aclk, aresetn, side_done_reg |-> !group_open_reg)
    `BLPBA_ASSERT_MSG(a_div_in_state, aclk, aresetn, div_rsp.busy |-> (state_reg == blpba_pkg::ST_DIV), "blpba: divider busy outside divide state")
    `BLPBA_ASSERT_MSG(a_ready_idle, aclk, aresetn, (s_tvalid && s_tready) |=> (state_reg == blpba_pkg::ST_MUL_PZ), "blpba: accepted level not sequenced")

endmodule

`default_nettype wire
